// ===== rtl/dsi_pkg.sv =====
package dsi_pkg;

    // field widths
    localparam int VEC_W  = 32;
    localparam int TIME_W = 24;
    localparam int RATE_W = 10;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register select, taken from paddr bit 2
    localparam logic REG_PHYSICS_RATE = 1'b0;

    localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

    // parameter defaults
    localparam int DSI_FRAC_BITS    = 16;
    localparam int DSI_MAX_SUBSTEPS = 16384;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic        [TIME_W-1:0] t_time;

endpackage

// ===== rtl/damped_substep_integrator.sv =====
// a request is taken only in the idle state; the block is not ready while a request is worked on
// the work runs as two divisions on the shared divider, then the one shared multiplier per lane
// per whole sub-step and for the remainder step; a stalled earlier result holds off the hand-over
// reset: synchronous, active low; clears the sequencer and output valid,
// physics_rate returns to 100
module damped_substep_integrator
    import dsi_pkg::*;
#(
    parameter int FRAC_BITS    = DSI_FRAC_BITS,
    parameter int MAX_SUBSTEPS = DSI_MAX_SUBSTEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_vec                  i_vel_x,
    input  t_vec                  i_vel_y,
    input  t_vec                  i_vel_z,
    input  t_vec                  i_disp_x,
    input  t_vec                  i_disp_y,
    input  t_vec                  i_disp_z,
    input  t_vec                  i_acc_x,
    input  t_vec                  i_acc_y,
    input  t_vec                  i_acc_z,
    input  t_time                 i_time_span,
    input  t_time                 i_friction,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_vec                  o_new_vel_x,
    output t_vec                  o_new_vel_y,
    output t_vec                  o_new_vel_z,
    output t_vec                  o_new_disp_x,
    output t_vec                  o_new_disp_y,
    output t_vec                  o_new_disp_z,
    output logic                  o_saturated,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // step length and divider width: holds 2^FRAC_BITS and any time span
    localparam int W_H   = (FRAC_BITS + 1 > TIME_W) ? FRAC_BITS + 1 : TIME_W;
    // multiplier operand a holds a sum of two vectors
    localparam int A_W   = VEC_W + 1;
    localparam int P_W   = A_W + W_H + 1;
    localparam int X_W   = P_W + 1;
    localparam int CNT_W = $clog2(MAX_SUBSTEPS + 1);
    localparam int DC_W  = $clog2(W_H);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_Q,
        S_DIV_N,
        S_REM_MUL,
        S_REM_SUB,
        S_HF_MUL,
        S_HF_CAP,
        S_AH_MUL,
        S_AH_SUM,
        S_DAMP_MUL,
        S_V1,
        S_DS_SUM,
        S_DS_MUL,
        S_DS_ADD,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [RATE_W-1:0] r_rate;

    // working set
    t_vec              r_vel  [3];
    t_vec              r_disp [3];
    t_vec              r_acc  [3];
    t_time             r_span;
    t_time             r_fric;
    logic              r_sat;
    logic [1:0]        r_lane;
    logic              r_last;
    logic [CNT_W-1:0]  r_cnt;
    logic [W_H-1:0]    r_q;
    logic [W_H-1:0]    r_h;
    logic [W_H-1:0]    r_rem_h;
    logic [TIME_W-1:0] r_hf;
    logic signed [A_W-1:0] r_sum;
    t_vec              r_tmp;
    logic signed [P_W-1:0] r_prod;

    // shared restoring divider
    logic [W_H-1:0]    r_dvd;
    logic [W_H-1:0]    r_dvs;
    logic [W_H-1:0]    r_drem;
    logic [DC_W-1:0]   r_dcnt;

    // output register
    logic              r_out_valid;
    t_vec              r_out_vel  [3];
    t_vec              r_out_disp [3];
    logic              r_out_sat;

    // saturation to the signed 32-bit range
    function automatic logic f_ovf(input logic signed [X_W-1:0] x);
        return !((&x[X_W-1:VEC_W-1]) || !(|x[X_W-1:VEC_W-1]));
    endfunction

    function automatic t_vec f_sat(input logic signed [X_W-1:0] x);
        t_vec res;
        if (f_ovf(x)) begin
            res = x[X_W-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
        end else begin
            res = x[VEC_W-1:0];
        end
        return res;
    endfunction

    // divider step
    logic [W_H:0]   div_sh;
    logic [W_H:0]   div_try;
    logic           div_bit;
    logic [W_H-1:0] div_rem_n;
    logic [W_H-1:0] div_quo_n;
    logic           div_end;

    assign div_sh    = {r_drem, r_dvd[W_H-1]};
    assign div_try   = div_sh - {1'b0, r_dvs};
    assign div_bit   = !div_try[W_H];
    assign div_rem_n = div_bit ? div_try[W_H-1:0] : div_sh[W_H-1:0];
    assign div_quo_n = {r_dvd[W_H-2:0], div_bit};
    assign div_end   = (r_dcnt == DC_W'(W_H - 1));

    // shared multiplier operands
    logic signed [A_W-1:0] mul_a;
    logic        [W_H-1:0] mul_b;
    logic signed [P_W-1:0] product;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_REM_MUL: begin
                mul_a = A_W'(r_cnt);
                mul_b = r_q;
            end
            S_HF_MUL: begin
                mul_a = A_W'(r_fric);
                mul_b = r_h;
            end
            S_AH_MUL: begin
                mul_a = A_W'(r_acc[r_lane]);
                mul_b = r_h;
            end
            S_DAMP_MUL: begin
                mul_a = r_sum;
                mul_b = W_H'(r_hf);
            end
            S_DS_MUL: begin
                mul_a = r_sum;
                mul_b = r_h;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = P_W'(mul_a) * P_W'($signed({1'b0, mul_b}));

    // products are floored by the arithmetic shifts
    logic signed [X_W-1:0] ah_x;
    logic signed [X_W-1:0] diff_x;
    logic signed [X_W-1:0] sd_x;
    t_vec                  ah;
    logic                  hf_big;

    assign ah_x   = X_W'(r_prod >>> FRAC_BITS);
    assign ah     = f_sat(ah_x);
    assign diff_x = X_W'(r_sum) - X_W'(r_prod >>> FRAC_BITS);
    assign sd_x   = X_W'(r_disp[r_lane]) + X_W'(r_prod >>> (FRAC_BITS + 1));
    assign hf_big = |r_prod[P_W-1:FRAC_BITS+TIME_W];

    logic in_acc;
    logic out_acc;
    logic out_load;
    logic cfg_wr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    // finished result moves over once the output register is free
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_PHYSICS_RATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_out_valid <= 1'b0;
            r_lane      <= '0;
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_sat       <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_rate <= pwdata[RATE_W-1:0];
            end
            // loaded on hand-over, kept until the result is taken
            r_out_valid <= out_load || (r_out_valid && !out_acc);

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_vel[0]  <= i_vel_x;
                        r_vel[1]  <= i_vel_y;
                        r_vel[2]  <= i_vel_z;
                        r_disp[0] <= i_disp_x;
                        r_disp[1] <= i_disp_y;
                        r_disp[2] <= i_disp_z;
                        r_acc[0]  <= i_acc_x;
                        r_acc[1]  <= i_acc_y;
                        r_acc[2]  <= i_acc_z;
                        r_span    <= i_time_span;
                        r_fric    <= i_friction;
                        r_sat     <= 1'b0;
                        r_lane    <= '0;
                        r_last    <= 1'b0;
                        // sub-step length: 2^FRAC_BITS over the rate, zero rate taken as one
                        r_dvd     <= W_H'(1) << FRAC_BITS;
                        r_dvs     <= (r_rate == '0) ? W_H'(1) : W_H'(r_rate);
                        r_drem    <= '0;
                        r_dcnt    <= '0;
                        r_state   <= S_DIV_Q;
                    end
                end
                S_DIV_Q: begin
                    if (div_end) begin
                        // step length never below one lsb
                        if (div_quo_n == '0) begin
                            r_q   <= W_H'(1);
                            r_dvs <= W_H'(1);
                        end else begin
                            r_q   <= div_quo_n;
                            r_dvs <= div_quo_n;
                        end
                        r_dvd   <= W_H'(r_span);
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV_N;
                    end else begin
                        r_drem <= div_rem_n;
                        r_dvd  <= div_quo_n;
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_DIV_N: begin
                    r_drem <= div_rem_n;
                    r_dvd  <= div_quo_n;
                    if (div_end) begin
                        // whole sub-steps, capped
                        if (div_quo_n > W_H'(MAX_SUBSTEPS)) begin
                            r_cnt <= CNT_W'(MAX_SUBSTEPS);
                        end else begin
                            r_cnt <= div_quo_n[CNT_W-1:0];
                        end
                        r_dcnt  <= '0;
                        r_state <= S_REM_MUL;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_REM_MUL: begin
                    r_prod  <= product;
                    r_state <= S_REM_SUB;
                end
                S_REM_SUB: begin
                    // remainder step covers whatever the whole sub-steps leave
                    r_rem_h <= W_H'(r_span) - r_prod[W_H-1:0];
                    r_h     <= r_q;
                    r_state <= S_HF_MUL;
                end
                S_HF_MUL: begin
                    r_prod  <= product;
                    r_state <= S_HF_CAP;
                end
                S_HF_CAP: begin
                    if (hf_big) begin
                        r_sat <= 1'b1;
                        r_hf  <= '1;
                    end else begin
                        r_hf  <= r_prod[FRAC_BITS+TIME_W-1:FRAC_BITS];
                    end
                    r_lane <= '0;
                    if (!r_last && r_cnt == '0) begin
                        // no whole sub-steps: straight on to the remainder step
                        r_h     <= r_rem_h;
                        r_last  <= 1'b1;
                        r_state <= S_HF_MUL;
                    end else begin
                        r_state <= S_AH_MUL;
                    end
                end
                S_AH_MUL: begin
                    r_prod  <= product;
                    r_state <= S_AH_SUM;
                end
                S_AH_SUM: begin
                    if (f_ovf(ah_x)) begin
                        r_sat <= 1'b1;
                    end
                    r_sum   <= A_W'(r_vel[r_lane]) + A_W'(ah);
                    r_state <= S_DAMP_MUL;
                end
                S_DAMP_MUL: begin
                    r_prod  <= product;
                    r_state <= S_V1;
                end
                S_V1: begin
                    if (f_ovf(diff_x)) begin
                        r_sat <= 1'b1;
                    end
                    r_tmp   <= f_sat(diff_x);
                    r_state <= S_DS_SUM;
                end
                S_DS_SUM: begin
                    // trapezoid: old plus new velocity
                    r_sum         <= A_W'(r_vel[r_lane]) + A_W'(r_tmp);
                    r_vel[r_lane] <= r_tmp;
                    r_state       <= S_DS_MUL;
                end
                S_DS_MUL: begin
                    r_prod  <= product;
                    r_state <= S_DS_ADD;
                end
                S_DS_ADD: begin
                    if (f_ovf(sd_x)) begin
                        r_sat <= 1'b1;
                    end
                    r_disp[r_lane] <= f_sat(sd_x);
                    if (r_lane != 2'd2) begin
                        r_lane  <= r_lane + 1'b1;
                        r_state <= S_AH_MUL;
                    end else begin
                        r_lane <= '0;
                        if (r_last) begin
                            r_state <= S_DONE;
                        end else if (r_cnt == CNT_W'(1)) begin
                            r_cnt   <= '0;
                            r_h     <= r_rem_h;
                            r_last  <= 1'b1;
                            r_state <= S_HF_MUL;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= S_AH_MUL;
                        end
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (out_load) begin
                        r_out_vel   <= r_vel;
                        r_out_disp  <= r_disp;
                        r_out_sat   <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_new_vel_x  = r_out_vel[0];
    assign o_new_vel_y  = r_out_vel[1];
    assign o_new_vel_z  = r_out_vel[2];
    assign o_new_disp_x = r_out_disp[0];
    assign o_new_disp_y = r_out_disp[1];
    assign o_new_disp_z = r_out_disp[2];
    assign o_saturated  = r_out_sat;

    // register read-back
    assign prdata = (paddr[2] == REG_PHYSICS_RATE) ? APB_DATA_W'(r_rate) : '0;
    assign pready = 1'b1;

endmodule

// ===== rtl/dsi_checker.sv =====
module dsi_checker
    import dsi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_vec                  o_new_vel_x,
    input t_vec                  o_new_vel_y,
    input t_vec                  o_new_vel_z,
    input t_vec                  o_new_disp_x,
    input t_vec                  o_new_disp_y,
    input t_vec                  o_new_disp_z,
    input logic                  o_saturated,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy");

    // no result can appear in the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // a stalled result holds
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_new_vel_x) && $stable(o_new_vel_y)
             && $stable(o_new_vel_z) && $stable(o_new_disp_x)
             && $stable(o_new_disp_y) && $stable(o_new_disp_z)
             && $stable(o_saturated)))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // rate register reads back what was written
    a_rate_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_PHYSICS_RATE)) |=>
            ((paddr[2] != REG_PHYSICS_RATE)
             || (prdata[RATE_W-1:0] == $past(pwdata[RATE_W-1:0]))))
        else $error("physics_rate read-back mismatch");

endmodule

bind damped_substep_integrator dsi_checker u_dsi_checker (.*);
